// File: hdl/iirbp_pkg.sv
// Shared types and fixed widths for the band-pass biquad with output clipping.
package iirbp_pkg;

  localparam int COEF_W     = 24;
  localparam int CLIP_W     = 15;
  localparam int Y_W        = 40;
  localparam int ACC_W      = 64;
  localparam int YSPLIT     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [ACC_W-1:0] Y_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] Y_MIN = 64'shFFFF_FF80_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FB1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FB2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT = 3'd5;

  // Where the registered product goes in the accumulate stage.
  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_MAIN = 2'd1,
    DST_LOAD = 2'd2,
    DST_HI   = 2'd3
  } acc_dst_t;

  typedef struct packed {
    logic     clr;
    acc_dst_t dst;
    logic     flush;
  } mac_ctrl_t;

endpackage

// File: hdl/iirbp_mac.sv
// Shared signed multiplier with a product register, a partial-term accumulator and the main sum.
module iirbp_mac
  import iirbp_pkg::*;
#(
  parameter int B_W       = 21,
  parameter int FRAC_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctrl_t               ctrl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [B_W-1:0]   operand,
  output logic signed [ACC_W-1:0] acc
);

  localparam int PW = COEF_W + B_W;

  logic signed [PW-1:0]    prod_r;
  acc_dst_t                dst_r;
  logic                    flush_r;
  logic signed [ACC_W-1:0] term_r, term_nxt;
  logic signed [ACC_W-1:0] main_r, main_nxt;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] term_shr;
  logic signed [ACC_W-1:0] main_add;

  assign prod_ext = ACC_W'(prod_r);
  // A feedback product is floored only after both halves are summed.
  assign term_shr = term_r >>> FRAC_BITS;

  always_comb begin
    term_nxt = term_r;
    unique case (dst_r)
      DST_NONE: term_nxt = term_r;
      DST_MAIN: term_nxt = term_r;
      DST_LOAD: term_nxt = prod_ext;
      DST_HI:   term_nxt = term_r + (prod_ext <<< YSPLIT);
    endcase
  end

  always_comb begin
    priority if (flush_r) begin
      main_add = term_shr;
    end else if (dst_r == DST_MAIN) begin
      main_add = prod_ext;
    end else begin
      main_add = '0;
    end
    main_nxt = ctrl.clr ? '0 : main_r + main_add;
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * operand;
    term_r <= term_nxt;
    main_r <= main_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r   <= DST_NONE;
      flush_r <= 1'b0;
    end else begin
      dst_r   <= ctrl.dst;
      flush_r <= ctrl.flush;
    end
  end

  assign acc = main_r;

endmodule

// File: hdl/iir_bandpass_biquad_clip_top.sv
// Top level of the band-pass biquad with output clipping and block tail values.
//
// Input requests carry one signed sample in in_tdata and the block-end mark in
// in_tlast. The first two samples of a block only fill the input history; unless
// in_tlast is set they leave the sequencer idle. Every later sample runs eight
// steps on one shared multiplier, then a drain state and an output state, in
// which its result is registered. A request with in_tlast set adds two tail
// results, the last one with out_tlast set; the block history is then cleared.
// in_tready is high only while the sequencer is idle. A result waits in the
// output register while out_tready is low, and the sequencer holds in its
// output step until the register is free; the next request can be taken while
// the last result still waits.
// Configuration writes on the cfg_ channel are always ready; they are meant for
// times when no request is in progress. Reset restores a0 = 1.0, the other
// coefficients to zero, the clip limit to 32767 and clears all history.
module iir_bandpass_biquad_clip_top
  import iirbp_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [SAMPLE_BITS-1:0] sample_in, rest zero
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [SAMPLE_BITS-1:0] filtered, rest zero
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data
);

  localparam int TD_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int B_W  = (SAMPLE_BITS > YSPLIT + 1) ? SAMPLE_BITS : YSPLIT + 1;
  localparam int E_W  = CLIP_W + 1;
  localparam logic [ACC_W-1:0] TRUNC_BIAS = (ACC_W'(1) << COEF_FRAC_BITS) - ACC_W'(1);
  localparam logic [2:0] STEP_TAIL = 3'd3;
  localparam logic [2:0] STEP_LAST = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    PH_Y  = 2'd0,
    PH_T1 = 2'd1,
    PH_T2 = 2'd2
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [2:0] step_r, step_nxt;

  logic signed [COEF_W-1:0] coef_a0_r, coef_a1_r, coef_a2_r, coef_fb1_r, coef_fb2_r;
  logic [CLIP_W-1:0]        clip_r;

  logic signed [SAMPLE_BITS-1:0] x_cur_r, x1_r, x2_r;
  logic signed [Y_W-1:0]         y1_r, y2_r;
  logic [1:0]                    seen_r;
  logic                          end_r;
  logic signed [E_W-1:0]         e1_r;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_data_r;
  logic                   out_last_r;

  mac_ctrl_t                ctrl;
  logic signed [COEF_W-1:0] op_coef;
  logic signed [B_W-1:0]    op_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  y_sat;
  logic signed [ACC_W-1:0]  emit_in;
  logic signed [E_W-1:0]    emit_q;

  logic in_acc, out_free, emit_go, last_step, prime, clr_go;
  logic signed [SAMPLE_BITS-1:0] in_sample;

  function automatic logic signed [ACC_W-1:0] sat_y(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    priority if (v > Y_MAX) begin
      r = Y_MAX;
    end else if (v < Y_MIN) begin
      r = Y_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Clip to the limit, otherwise truncate toward zero to an integer.
  function automatic logic signed [E_W-1:0] emit_val(input logic signed [ACC_W-1:0] v,
                                                     input logic [CLIP_W-1:0] lim);
    logic signed [ACC_W-1:0] lq;
    logic signed [ACC_W-1:0] rnd;
    logic signed [E_W-1:0]   r;
    lq  = ACC_W'(lim);
    lq  = lq <<< COEF_FRAC_BITS;
    rnd = v + (v[ACC_W-1] ? TRUNC_BIAS : '0);
    priority if (v < -lq) begin
      r = -$signed({1'b0, lim});
    end else if (v > lq) begin
      r = $signed({1'b0, lim});
    end else begin
      r = E_W'(rnd >>> COEF_FRAC_BITS);
    end
    return r;
  endfunction

  assign in_sample = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign prime     = (seen_r != 2'd2);
  assign out_free  = !out_valid_r || out_tready;
  assign emit_go   = (state_r == ST_EMIT) && out_free;
  assign last_step = (phase_r == PH_T2) ? (step_r == STEP_TAIL) : (step_r == STEP_LAST);

  assign cfg_ready = 1'b1;

  // Operand selection for the shared multiplier.
  always_comb begin
    op_coef    = '0;
    op_b       = '0;
    ctrl.clr   = clr_go;
    ctrl.dst   = DST_NONE;
    ctrl.flush = 1'b0;
    if (state_r == ST_MAC) begin
      if (phase_r == PH_T2) begin
        unique case (step_r[1:0])
          2'd0: begin
            op_coef  = coef_fb1_r;
            op_b     = B_W'(e1_r);
            ctrl.dst = DST_MAIN;
          end
          2'd1: begin
            op_coef  = coef_fb2_r;
            op_b     = B_W'({1'b0, y1_r[YSPLIT-1:0]});
            ctrl.dst = DST_LOAD;
          end
          2'd2: begin
            op_coef  = coef_fb2_r;
            op_b     = B_W'($signed(y1_r[Y_W-1:YSPLIT]));
            ctrl.dst = DST_HI;
          end
          2'd3: begin
            ctrl.flush = 1'b1;
          end
        endcase
      end else begin
        unique case (step_r)
          3'd0: begin
            op_coef  = coef_a0_r;
            op_b     = B_W'(x_cur_r);
            ctrl.dst = DST_MAIN;
          end
          3'd1: begin
            op_coef  = coef_a1_r;
            op_b     = B_W'(x1_r);
            ctrl.dst = DST_MAIN;
          end
          3'd2: begin
            op_coef  = coef_a2_r;
            op_b     = B_W'(x2_r);
            ctrl.dst = DST_MAIN;
          end
          3'd3: begin
            op_coef  = coef_fb1_r;
            op_b     = B_W'({1'b0, y1_r[YSPLIT-1:0]});
            ctrl.dst = DST_LOAD;
          end
          3'd4: begin
            op_coef  = coef_fb1_r;
            op_b     = B_W'($signed(y1_r[Y_W-1:YSPLIT]));
            ctrl.dst = DST_HI;
          end
          3'd5: begin
            op_coef    = coef_fb2_r;
            op_b       = B_W'({1'b0, y2_r[YSPLIT-1:0]});
            ctrl.dst   = DST_LOAD;
            ctrl.flush = 1'b1;
          end
          3'd6: begin
            op_coef  = coef_fb2_r;
            op_b     = B_W'($signed(y2_r[Y_W-1:YSPLIT]));
            ctrl.dst = DST_HI;
          end
          3'd7: begin
            ctrl.flush = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    clr_go    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!prime) begin
            state_nxt = ST_MAC;
            phase_nxt = PH_Y;
            step_nxt  = '0;
            clr_go    = 1'b1;
          end else if (in_tlast) begin
            state_nxt = ST_MAC;
            phase_nxt = PH_T1;
            step_nxt  = STEP_TAIL;
            clr_go    = 1'b1;
          end
        end
      end
      ST_MAC: begin
        step_nxt = step_r + 3'd1;
        if (last_step) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          unique case (phase_r)
            PH_Y: begin
              if (end_r) begin
                state_nxt = ST_MAC;
                phase_nxt = PH_T1;
                step_nxt  = STEP_TAIL;
                clr_go    = 1'b1;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
            PH_T1: begin
              state_nxt = ST_MAC;
              phase_nxt = PH_T2;
              step_nxt  = '0;
              clr_go    = 1'b1;
            end
            PH_T2: begin
              state_nxt = ST_IDLE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign y_sat   = sat_y(acc);
  assign emit_in = (phase_r == PH_Y) ? y_sat : acc;
  assign emit_q  = emit_val(emit_in, clip_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_Y;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a0_r  <= 24'sd1048576;
      coef_a1_r  <= '0;
      coef_a2_r  <= '0;
      coef_fb1_r <= '0;
      coef_fb2_r <= '0;
      clip_r     <= 15'd32767;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COEF_A0)    coef_a0_r  <= $signed(cfg_data[COEF_W-1:0]);
      if (cfg_index == REG_COEF_A1)    coef_a1_r  <= $signed(cfg_data[COEF_W-1:0]);
      if (cfg_index == REG_COEF_A2)    coef_a2_r  <= $signed(cfg_data[COEF_W-1:0]);
      if (cfg_index == REG_COEF_FB1)   coef_fb1_r <= $signed(cfg_data[COEF_W-1:0]);
      if (cfg_index == REG_COEF_FB2)   coef_fb2_r <= $signed(cfg_data[COEF_W-1:0]);
      if (cfg_index == REG_CLIP_LIMIT) clip_r     <= cfg_data[CLIP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r   <= '0;
      x2_r   <= '0;
      y1_r   <= '0;
      y2_r   <= '0;
      seen_r <= '0;
      end_r  <= 1'b0;
    end else if (in_acc) begin
      end_r <= in_tlast;
      if (prime) begin
        seen_r <= seen_r + 2'd1;
        x2_r   <= x1_r;
        x1_r   <= in_sample;
      end
    end else if (emit_go) begin
      unique case (phase_r)
        PH_Y: begin
          y2_r <= y1_r;
          y1_r <= y_sat[Y_W-1:0];
          x2_r <= x1_r;
          x1_r <= x_cur_r;
        end
        PH_T1: begin
        end
        PH_T2: begin
          x1_r   <= '0;
          x2_r   <= '0;
          y1_r   <= '0;
          y2_r   <= '0;
          seen_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_cur_r <= in_sample;
    end
    if (emit_go && (phase_r == PH_T1)) begin
      e1_r <= emit_q;
    end
    if (emit_go) begin
      out_data_r <= SAMPLE_BITS'(emit_q);
      out_last_r <= (phase_r == PH_T2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TD_W'(out_data_r);
  assign out_tlast  = out_last_r;

  iirbp_mac #(
    .B_W       (B_W),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .coef    (op_coef),
    .operand (op_b),
    .acc     (acc)
  );

endmodule

// File: dv/iir_bandpass_biquad_clip_top_tb.sv
// Self-checking testbench for the clipped band-pass biquad with block tail values.
`timescale 1ns / 100ps

module iir_bandpass_biquad_clip_top_tb
  import iirbp_pkg::*;
();

  localparam int SMP_W        = 16;
  localparam int FRAC         = 20;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic signed [SMP_W-1:0] value;
    logic                    done;
  } filt_out_t;

  // One directed request; when typed is set, the n_res results are v0..v2.
  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic                    last;
    logic                    typed;
    logic [1:0]              n_res;
    logic signed [SMP_W-1:0] v0;
    logic signed [SMP_W-1:0] v1;
    logic signed [SMP_W-1:0] v2;
  } stim_row_t;

  localparam stim_row_t DIRECTED [15] = '{
    '{100,    1'b0, 1'b1, 2'd0, 0,      0, 0},
    '{-1,     1'b0, 1'b1, 2'd0, 0,      0, 0},
    '{32767,  1'b0, 1'b1, 2'd1, 32767,  0, 0},
    '{-32768, 1'b0, 1'b1, 2'd1, -32767, 0, 0},
    '{0,      1'b0, 1'b1, 2'd1, 0,      0, 0},
    '{-1,     1'b0, 1'b1, 2'd1, -1,     0, 0},
    '{21845,  1'b0, 1'b0, 2'd0, 0,      0, 0},
    '{-21846, 1'b0, 1'b0, 2'd0, 0,      0, 0},
    '{1234,   1'b1, 1'b1, 2'd3, 1234,   0, 0},
    '{-32768, 1'b1, 1'b1, 2'd2, 0,      0, 0},
    '{5,      1'b0, 1'b1, 2'd0, 0,      0, 0},
    '{32767,  1'b1, 1'b1, 2'd2, 0,      0, 0},
    '{-300,   1'b0, 1'b0, 2'd0, 0,      0, 0},
    '{300,    1'b0, 1'b0, 2'd0, 0,      0, 0},
    '{7,      1'b1, 1'b0, 2'd0, 0,      0, 0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SMP_W-1:0]       in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [SMP_W-1:0]       out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int   snd_idle  = 0;
  int   rcv_stall = 0;
  logic hold_req  = 1'b0;

  int n_sent = 0;
  int n_blocks = 0;
  int n_settings = 0;
  int n_checked = 0;
  int n_fail = 0;
  int quiet_cycles = 0;

  // Filter state and registers as the block should hold them.
  logic signed [COEF_W-1:0] gain_x0, gain_x1, gain_x2, gain_y1, gain_y2;
  logic [CLIP_W-1:0]        clip_bound;
  logic signed [SMP_W-1:0]  hist_x1, hist_x2;
  logic signed [Y_W-1:0]    hist_y1, hist_y2;
  int                       fill_cnt;

  filt_out_t step_res [3];
  int        step_n;
  filt_out_t pending_outputs [$];

  iir_bandpass_biquad_clip_top #(
    .SAMPLE_BITS    (SMP_W),
    .COEF_FRAC_BITS (FRAC)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Feedback product brought back to FRAC fractional bits, rounded toward minus infinity.
  function automatic longint fb_term(input logic signed [COEF_W-1:0] c,
                                     input logic signed [Y_W-1:0] y);
    return (longint'(c) * longint'(y)) >>> FRAC;
  endfunction

  function automatic logic signed [SMP_W-1:0] clip_out(input longint yq);
    longint lim;
    longint r;
    lim = longint'(clip_bound) <<< FRAC;
    if (yq < -lim) r = -longint'(clip_bound);
    else if (yq > lim) r = longint'(clip_bound);
    else if (yq >= 0) r = yq >>> FRAC;
    else r = -((-yq) >>> FRAC);
    return r[SMP_W-1:0];
  endfunction

  function automatic void filter_step(input logic signed [SMP_W-1:0] x, input logic last);
    longint acc;
    longint t1;
    longint t2;
    logic signed [SMP_W-1:0] e1;
    step_n = 0;
    if (fill_cnt >= 2) begin
      acc = longint'(x) * longint'(gain_x0) + longint'(hist_x1) * longint'(gain_x1)
          + longint'(hist_x2) * longint'(gain_x2)
          + fb_term(gain_y1, hist_y1) + fb_term(gain_y2, hist_y2);
      if (acc > Y_MAX) acc = Y_MAX;
      else if (acc < Y_MIN) acc = Y_MIN;
      hist_y2 = hist_y1;
      hist_y1 = acc[Y_W-1:0];
      step_res[step_n] = '{clip_out(acc), 1'b0};
      step_n++;
    end else begin
      fill_cnt++;
    end
    hist_x2 = hist_x1;
    hist_x1 = x;
    if (last) begin
      // Two tail values run the feedback path on with zero input.
      t1 = fb_term(gain_y1, hist_y1) + fb_term(gain_y2, hist_y2);
      e1 = clip_out(t1);
      t2 = longint'(gain_y1) * longint'(e1) + fb_term(gain_y2, hist_y1);
      step_res[step_n] = '{e1, 1'b0};
      step_res[step_n+1] = '{clip_out(t2), 1'b1};
      step_n += 2;
      hist_x1 = '0;
      hist_x2 = '0;
      hist_y1 = '0;
      hist_y2 = '0;
      fill_cnt = 0;
    end
  endfunction

  task automatic send_sample(input logic signed [SMP_W-1:0] smp, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic apply_sample(input logic signed [SMP_W-1:0] smp, input logic last);
    send_sample(smp, last);
    filter_step(smp, last);
    for (int k = 0; k < step_n; k++) pending_outputs.push_back(step_res[k]);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COEF_A0:    gain_x0 = data;
      REG_COEF_A1:    gain_x1 = data;
      REG_COEF_A2:    gain_x2 = data;
      REG_COEF_FB1:   gain_y1 = data;
      REG_COEF_FB2:   gain_y2 = data;
      REG_CLIP_LIMIT: clip_bound = data[CLIP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [CFG_DATA_W-1:0] a0, a1, a2, b1, b2, lim_word);
    cfg_write(REG_COEF_A0, a0);
    cfg_write(REG_COEF_A1, a1);
    cfg_write(REG_COEF_A2, a2);
    cfg_write(REG_COEF_FB1, b1);
    cfg_write(REG_COEF_FB2, b2);
    cfg_write(REG_CLIP_LIMIT, lim_word);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Wait until every expected result is out, then let the tail of a
  // history-only request finish before anything is reconfigured.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return SMP_W'(int'($urandom_range(16)) - 8);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    return CFG_DATA_W'(int'($urandom_range(2097151)) - 1048576);
  endfunction

  task automatic run_blocks(input int n_items, input int idle_pct, input int stall_pct);
    int cnt;
    int len;
    cnt = 0;
    snd_idle = idle_pct;
    rcv_stall = stall_pct;
    while (cnt < n_items) begin
      // Most blocks are long enough to reach the filter path; some end early.
      if ($urandom_range(99) < 15) len = $urandom_range(1, 2);
      else len = $urandom_range(3, 12);
      for (int k = 0; k < len; k++) apply_sample(rand_sample(), k == len - 1);
      cnt += len;
      n_blocks++;
    end
    settle();
  endtask

  always @(posedge clk) begin
    filt_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, got %0d (last %0b)",
                   $time, $signed(out_tdata), out_tlast);
      end else begin
        want = pending_outputs.pop_front();
        n_checked++;
        if (out_tdata !== want.value || out_tlast !== want.done) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: result mismatch: expected %0d (last %0b), got %0d (last %0b)",
                     $time, $signed(want.value), want.done, $signed(out_tdata), out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_outputs.size());
      $display("** iir_bandpass_biquad_clip_top: FAILED **");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int h = 0; h < HOLD_CYCLES; h++) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  initial begin
    stim_row_t row;
    logic signed [SMP_W-1:0] typed_v [3];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_COEF_A0;
    cfg_data  = '0;
    gain_x0    = 24'sd1048576;
    gain_x1    = '0;
    gain_x2    = '0;
    gain_y1    = '0;
    gain_y2    = '0;
    clip_bound = 15'd32767;
    hist_x1    = '0;
    hist_x2    = '0;
    hist_y1    = '0;
    hist_y2    = '0;
    fill_cnt   = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: unity gain, no feedback, full range.
    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      send_sample(row.smp, row.last);
      filter_step(row.smp, row.last);
      if (row.typed) begin
        typed_v = '{row.v0, row.v1, row.v2};
        for (int k = 0; k < row.n_res; k++)
          pending_outputs.push_back('{typed_v[k], row.last && (k == row.n_res - 1)});
      end else begin
        for (int k = 0; k < step_n; k++) pending_outputs.push_back(step_res[k]);
      end
      if (row.last) n_blocks++;
    end
    settle();

    // Narrow resonator near its stability edge, no idling.
    write_settings(CFG_DATA_W'(52429), CFG_DATA_W'(0), CFG_DATA_W'(-52429),
                   CFG_DATA_W'(1992294), CFG_DATA_W'(-946340), CFG_DATA_W'(32767));
    run_blocks(55, 0, 0);

    // Largest coefficients; the clip word carries bits above the register width.
    write_settings(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF);
    run_blocks(45, 61, 0);

    // Most negative coefficients and a clip limit of zero.
    write_settings(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h008000);
    run_blocks(40, 0, 61);

    write_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    run_blocks(50, 17, 17);

    // The result side holds off for a long stretch while samples keep coming.
    write_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                   CFG_DATA_W'($urandom_range(32767)));
    hold_req = 1'b1;
    run_blocks(50, 0, 0);

    write_settings(CFG_DATA_W'(1048576), rand_gain(), rand_gain(), CFG_DATA_W'(1048576),
                   CFG_DATA_W'(-524288), CFG_DATA_W'($urandom_range(32767)));
    run_blocks(55, 17, 17);

    $display("Covered %0d samples in %0d blocks under %0d coefficient settings.",
             n_sent, n_blocks, n_settings + 1);
    $display("Checked %0d results, %0d failures.", n_checked, n_fail);
    if (n_fail == 0)
      $display("** iir_bandpass_biquad_clip_top: PASSED **");
    else
      $display("** iir_bandpass_biquad_clip_top: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
hdl/iirbp_pkg.sv
hdl/iirbp_mac.sv
hdl/iir_bandpass_biquad_clip_top.sv
dv/iir_bandpass_biquad_clip_top_tb.sv
